[sv/assert_macros.svh]
// Assertion shorthands shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, quiet while rst is high.
`define FCA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clk, also checked through reset.
`define FCA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/fca_pkg.sv]
// ----------------------------------------------------------------------------
// fca_pkg
// Shared constants for the allocation table chain block: sizes, request codes
// and table entry markers.
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int MAX_CHAIN_DEF     = 64;

  localparam int BLK_W = 8;   // block number and table entry width
  localparam int CNT_W = 7;   // num_blocks width

  localparam logic [BLK_W-1:0] FDB_RESET      = 8'd27;
  localparam logic [BLK_W-1:0] MIN_DATA_BLOCK = 8'd2;
  localparam logic [BLK_W-1:0] FREE_ENTRY     = 8'd0;
  localparam logic [BLK_W-1:0] END_MARK       = 8'd1;

  localparam logic [1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

endpackage

[sv/fca_ram.sv]
// ----------------------------------------------------------------------------
// fca_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/fat_chain_allocator.sv]
// ----------------------------------------------------------------------------
// fat_chain_allocator
// File allocation table with allocate, read and delete of block chains.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries func, head_blk, num_blocks.
//   in_stall is high while a request is in progress; one request at a time.
//   Output channel (out_valid/out_stall) carries block, last, ok, one item per
//   block in chain order, last set on the final item of a request.
//   Allocate: one table read per cycle scans upward from first_data_block
//   (never below block 2), then each item passes through the chain buffer
//   (states ERD, ELD), and a final table write places the end marker.
//   A failed allocation gives a single item (block 0, last 1, ok 0).
//   Read and delete: the walk follows the chain (table read feeds the next
//   address), then items go through the chain buffer. Delete clears entries
//   as items are issued. Unknown func or zero num_blocks is taken and dropped
//   with no items. The output register lets a request start while the
//   previous last item still waits; a stalled receiver holds the item and
//   pauses the sequencer. Reset clears every table entry (per-entry valid
//   bits) and sets first_data_block to 27. cfg_wr_en writes it; the user
//   must write it only while idle, and the block does not enforce that.
// ----------------------------------------------------------------------------
module fat_chain_allocator
  import fca_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_CHAIN     = MAX_CHAIN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [BLK_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       func,
  input  logic [BLK_W-1:0] head_blk,
  input  logic [CNT_W-1:0] num_blocks,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [BLK_W-1:0] block,
  output logic             last,
  output logic             ok
);

  localparam int TAW = $clog2(TABLE_ENTRIES);
  localparam int CW  = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam logic [BLK_W:0]   TE_LIM  = (BLK_W + 1)'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHAIN);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_WALK = 7'b0000100,
    S_ERD  = 7'b0001000,
    S_ELD  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_FAIL = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [BLK_W-1:0] fdb;
  logic [1:0]       func_q, func_q_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [BLK_W:0]   scan_idx, scan_idx_next;
  logic             p_valid, p_valid_next;
  logic [BLK_W:0]   p_idx, p_idx_next;
  logic [BLK_W-1:0] start_q, start_q_next;
  logic [BLK_W-1:0] prev, prev_next;

  logic [TABLE_ENTRIES-1:0] tv;
  logic             tv_rd, tv_rd_next;

  logic             out_valid_next;
  logic [BLK_W-1:0] block_next;
  logic             last_next, ok_next;

  // table RAM
  logic [BLK_W:0]   rd_ptr;
  logic             t_wreq, t_we;
  logic [BLK_W:0]   t_waddr;
  logic [BLK_W-1:0] t_wdata, t_rdata, tval;

  // chain buffer
  logic             c_we;
  logic [BLK_W-1:0] c_wdata, c_rdata;

  logic             out_free, in_take, hit, last_v;
  logic [CNT_W-1:0] found_next;
  logic [BLK_W-1:0] cur_val, scan_start;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign tval     = tv_rd ? t_rdata : FREE_ENTRY;
  assign t_we     = t_wreq && (t_waddr < TE_LIM);
  assign scan_start = (fdb < MIN_DATA_BLOCK) ? MIN_DATA_BLOCK : fdb;

  fca_ram #(.WIDTH(BLK_W), .DEPTH(TABLE_ENTRIES), .AW(TAW)) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr[TAW-1:0]),
    .wdata (t_wdata),
    .raddr (rd_ptr[TAW-1:0]),
    .rdata (t_rdata)
  );

  fca_ram #(.WIDTH(BLK_W), .DEPTH(MAX_CHAIN), .AW(CW)) u_chain (
    .clk   (clk),
    .we    (c_we),
    .waddr (idx[CW-1:0]),
    .wdata (c_wdata),
    .raddr (idx[CW-1:0]),
    .rdata (c_rdata)
  );

  always_comb begin
    state_next     = state;
    func_q_next    = func_q;
    cnt_next       = cnt;
    idx_next       = idx;
    scan_idx_next  = scan_idx;
    p_valid_next   = 1'b0;
    p_idx_next     = scan_idx;
    start_q_next   = start_q;
    prev_next      = prev;
    rd_ptr         = scan_idx;
    t_wreq         = 1'b0;
    t_waddr        = {1'b0, prev};
    t_wdata        = FREE_ENTRY;
    c_we           = 1'b0;
    c_wdata        = p_idx[BLK_W-1:0];
    out_valid_next = out_valid && out_stall;
    block_next     = block;
    last_next      = last;
    ok_next        = ok;
    hit            = p_valid && (tval == FREE_ENTRY);
    found_next     = idx + CNT_W'(hit);
    cur_val        = (idx == '0) ? start_q : tval;
    last_v         = ((idx + 1'b1) == cnt);

    case (state)
      S_IDLE: begin
        if (in_take && (func <= FUNC_DELETE) && (num_blocks != '0)) begin
          func_q_next   = func;
          cnt_next      = (num_blocks > CNT_MAX) ? CNT_MAX : num_blocks;
          idx_next      = '0;
          start_q_next  = head_blk;
          scan_idx_next = {1'b0, scan_start};
          state_next    = (func == FUNC_ALLOC) ? S_SCAN : S_WALK;
        end
      end
      S_SCAN: begin
        // issue one read per cycle, check the registered data of the previous read
        p_valid_next = (scan_idx < TE_LIM);
        if (scan_idx < TE_LIM) begin
          scan_idx_next = scan_idx + 1'b1;
        end
        if (hit) begin
          c_we     = 1'b1;
          idx_next = found_next;
        end
        if (found_next == cnt) begin
          idx_next   = '0;
          state_next = S_ERD;
        end else if (!p_valid && (scan_idx >= TE_LIM)) begin
          state_next = S_FAIL;
        end
      end
      S_WALK: begin
        // read data of this link is the address of the next one
        rd_ptr   = {1'b0, cur_val};
        c_we     = 1'b1;
        c_wdata  = cur_val;
        idx_next = idx + 1'b1;
        if (last_v) begin
          idx_next   = '0;
          state_next = S_ERD;
        end
      end
      S_ERD: begin
        state_next = S_ELD;
      end
      S_ELD: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          block_next     = c_rdata;
          last_next      = last_v;
          ok_next        = 1'b1;
          if (func_q == FUNC_ALLOC) begin
            // link the previous block to this one
            t_wreq  = (idx != '0);
            t_waddr = {1'b0, prev};
            t_wdata = c_rdata;
          end else if (func_q == FUNC_DELETE) begin
            t_wreq  = 1'b1;
            t_waddr = {1'b0, c_rdata};
            t_wdata = FREE_ENTRY;
          end
          prev_next = c_rdata;
          idx_next  = idx + 1'b1;
          if (last_v) begin
            state_next = (func_q == FUNC_ALLOC) ? S_FIN : S_IDLE;
          end else begin
            state_next = S_ERD;
          end
        end
      end
      S_FIN: begin
        t_wreq     = 1'b1;
        t_waddr    = {1'b0, prev};
        t_wdata    = END_MARK;
        state_next = S_IDLE;
      end
      S_FAIL: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          block_next     = FREE_ENTRY;
          last_next      = 1'b1;
          ok_next        = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    tv_rd_next = (rd_ptr < TE_LIM) && tv[rd_ptr[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fdb       <= FDB_RESET;
      tv        <= '0;
      out_valid <= 1'b0;
      p_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      p_valid   <= p_valid_next;
      if (cfg_wr_en) begin
        fdb <= cfg_wr_data;
      end
      if (t_we) begin
        tv[t_waddr[TAW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_q   <= func_q_next;
    cnt      <= cnt_next;
    idx      <= idx_next;
    scan_idx <= scan_idx_next;
    p_idx    <= p_idx_next;
    start_q  <= start_q_next;
    prev     <= prev_next;
    tv_rd    <= tv_rd_next;
    block    <= block_next;
    last     <= last_next;
    ok       <= ok_next;
  end

endmodule

[sv/fca_checker.sv]
// ----------------------------------------------------------------------------
// fca_checker
// Port-level checks for the allocation table chain block, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fca_checker
  import fca_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             cfg_wr_en,
  input logic [BLK_W-1:0] cfg_wr_data,
  input logic             in_valid,
  input logic             in_stall,
  input logic [1:0]       func,
  input logic [BLK_W-1:0] head_blk,
  input logic [CNT_W-1:0] num_blocks,
  input logic             out_valid,
  input logic             out_stall,
  input logic [BLK_W-1:0] block,
  input logic             last,
  input logic             ok
);

  // a stalled result item holds
  `FCA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(block) && $stable(last) && $stable(ok), "stalled output item changed")

  // failure is always a single item with block 0
  `FCA_ASSERT(a_fail_form, out_valid && !ok |-> last && (block == FREE_ENTRY), "malformed failure item")

  // a real request makes the block busy on the next cycle
  `FCA_ASSERT(a_busy_after_req, in_valid && !in_stall && (func <= FUNC_DELETE) && (num_blocks != '0) |=> in_stall, "request taken but not busy")

  // reset leaves the block idle with no pending item
  `FCA_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (.*);
